// File: rtl/aig_strash_node_table_macros.svh
// assertion helpers for the node table
`ifndef AIG_STRASH_NODE_TABLE_MACROS_SVH
`define AIG_STRASH_NODE_TABLE_MACROS_SVH

// implication checked on every clock edge outside reset
`define AST_IMPLY(name, cond, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// implication whose property is checked in the cycle after the condition
`define AST_NEXT(name, cond, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// File: rtl/aig_pkg.sv
`timescale 1ns / 1ps
package aig_pkg;

	localparam int MAX_NODES  = 4096;
	localparam int HASH_SLOTS = 8192;
	localparam int NODE_W     = $clog2(MAX_NODES);
	localparam int LIT_W      = 13;
	localparam int KEY_W      = 2 * LIT_W;
	localparam int SLOT_W     = $clog2(HASH_SLOTS);
	localparam int CNT_W      = 13;
	localparam int NFREE_W    = NODE_W + 1;

	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	localparam logic [1:0] OP_INPUT  = 2'd0;
	localparam logic [1:0] OP_AND    = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_ILLEGAL = 2'd2;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [LIT_W-1:0] lit_a;
		logic [LIT_W-1:0] lit_b;
		logic [11:0]      node_index;
	} req_t;

	typedef struct packed {
		logic [LIT_W-1:0] result_lit;
		logic             created;
		logic [1:0]       status;
	} rsp_t;

endpackage

// File: rtl/aig_strash_node_table.sv
`timescale 1ns / 1ps
// And-inverter graph node table with structural hashing.
// Request channel req_valid/req_ready carries one item: opcode, two fanin
// literals and a node index. Response channel rsp_valid/rsp_ready returns one
// item per request: result literal, created flag and status.
// Items are handled one at a time by a sequencer around two synchronous
// memories with one read and one write port each: a hash slot memory (key
// and node id, linear probing) and a node memory (input mark, dead mark,
// reference count, fanin pair). A trivial and, an unused opcode and an
// input with the table full go straight to the done state; a new input
// writes its node entry; a remove reads the node entry and, when legal,
// reads and writes each fanin count; a new and reads a slot per probe step,
// the node on a key match and, when a node is allocated, writes it and
// updates both fanin counts. The done state loads the response register.
// After reset both memories are swept clear, one slot a cycle, until every
// hash slot is cleared; req_ready stays low meanwhile. A waiting response
// is held in the output register until rsp_ready; a finished item waits in
// the done state until it can be loaded; req_ready is high only in idle.
module aig_strash_node_table import aig_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	`include "aig_strash_node_table_macros.svh"

	typedef enum logic [9:0] {
		S_CLEAR   = 10'b0000000001,
		S_IDLE    = 10'b0000000010,
		S_PROBE   = 10'b0000000100,
		S_SLOT    = 10'b0000001000,
		S_LIVE    = 10'b0000010000,
		S_NODE_WR = 10'b0000100000,
		S_REM_CHK = 10'b0001000000,
		S_BUMP_RD = 10'b0010000000,
		S_BUMP_WR = 10'b0100000000,
		S_DONE    = 10'b1000000000
	} state_t;

	typedef struct packed {
		logic             used;
		logic [KEY_W-1:0] key;
		logic [NODE_W-1:0] node;
	} slot_t;

	typedef struct packed {
		logic             input_mark;
		logic             dead_mark;
		logic [CNT_W-1:0] fanout_cnt;
		logic [KEY_W-1:0] pair;
	} node_t;

	slot_t slot_mem [HASH_SLOTS];
	node_t node_mem [MAX_NODES];

	state_t              state_q;
	logic [SLOT_W-1:0]   clr_q;
	logic [NFREE_W-1:0]  next_free_q;
	logic [SLOT_W-1:0]   hptr_q;
	logic [KEY_W-1:0]    key_q;
	logic [LIT_W-1:0]    lo_q;
	logic [LIT_W-1:0]    hi_q;
	logic [NODE_W-1:0]   id_q;
	logic                is_input_q;
	logic [NODE_W-1:0]   bn0_q;
	logic [NODE_W-1:0]   bn1_q;
	logic                bup_q;
	logic                bsel_q;
	rsp_t                res_q;
	rsp_t                rsp_q;
	logic                rsp_valid_q;

	slot_t               slot_rd;
	node_t               node_rd;
	logic                slot_we;
	logic [SLOT_W-1:0]   slot_waddr;
	slot_t               slot_wdata;
	logic                node_we;
	logic [NODE_W-1:0]   node_waddr;
	node_t               node_wdata;
	logic [NODE_W-1:0]   node_raddr;
	logic [NODE_W-1:0]   bump_node;
	logic [CNT_W-1:0]    bump_cnt;
	logic                full;
	logic                rem_ok;
	logic [LIT_W-1:0]    lit_lo;
	logic [LIT_W-1:0]    lit_hi;
	logic                trivial;
	logic [LIT_W-1:0]    trivial_lit;
	logic [KEY_W-1:0]    new_key;
	logic [SLOT_W-1:0]   new_hash;
	rsp_t                idle_res;

	assign full      = next_free_q >= NFREE_W'(MAX_NODES);
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// folding rules for a two-input and
	always_comb begin
		trivial     = 1'b1;
		trivial_lit = '0;
		if (req.lit_a == LIT_W'(0) || req.lit_b == LIT_W'(0)) begin
			trivial_lit = '0;
		end else if (req.lit_a == LIT_W'(1)) begin
			trivial_lit = req.lit_b;
		end else if (req.lit_b == LIT_W'(1) || req.lit_a == req.lit_b) begin
			trivial_lit = req.lit_a;
		end else if (req.lit_a == (req.lit_b ^ LIT_W'(1))) begin
			trivial_lit = '0;
		end else begin
			trivial = 1'b0;
		end
	end

	// response of an item finished straight from idle
	always_comb begin
		idle_res = '0;
		if (req.opcode == OP_INPUT && full) begin
			idle_res.status = ST_FULL;
		end else if (req.opcode == OP_AND && trivial) begin
			idle_res.result_lit = trivial_lit;
		end
	end

	// ordered pair and its hash slot
	assign lit_lo   = (req.lit_b < req.lit_a) ? req.lit_b : req.lit_a;
	assign lit_hi   = (req.lit_b < req.lit_a) ? req.lit_a : req.lit_b;
	assign new_key  = {lit_lo, lit_hi};
	assign new_hash = SLOT_W'(new_key) ^ SLOT_W'(new_key >> 9) ^ SLOT_W'(new_key >> 17);

	// removal legality from the node entry just read
	assign rem_ok = (id_q != '0) && ({1'b0, id_q} < next_free_q) &&
		!node_rd.input_mark && !node_rd.dead_mark && (node_rd.fanout_cnt == '0);

	// saturating reference count update
	assign bump_node = bsel_q ? bn1_q : bn0_q;
	always_comb begin
		bump_cnt = node_rd.fanout_cnt;
		if (bup_q) begin
			if (node_rd.fanout_cnt != COUNT_MAX) bump_cnt = node_rd.fanout_cnt + CNT_W'(1);
		end else begin
			if (node_rd.fanout_cnt != '0) bump_cnt = node_rd.fanout_cnt - CNT_W'(1);
		end
	end

	// node memory read address
	always_comb begin
		case (state_q)
			S_IDLE:    node_raddr = (req.opcode == OP_REMOVE) ? req.node_index
				: next_free_q[NODE_W-1:0];
			S_SLOT:    node_raddr = slot_rd.used ? slot_rd.node : next_free_q[NODE_W-1:0];
			S_BUMP_RD: node_raddr = bump_node;
			default:   node_raddr = '0;
		endcase
	end

	// memory write ports
	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = hptr_q;
		slot_wdata = '{used: 1'b1, key: key_q, node: next_free_q[NODE_W-1:0]};
		node_we    = 1'b0;
		node_waddr = id_q;
		node_wdata = node_rd;
		case (state_q)
			S_CLEAR: begin
				slot_we    = 1'b1;
				slot_waddr = clr_q;
				slot_wdata = '0;
				node_we    = 1'b1;
				node_waddr = clr_q[NODE_W-1:0];
				node_wdata = '0;
			end
			S_SLOT: begin
				slot_we = !slot_rd.used && !full;
			end
			S_NODE_WR: begin
				node_we                = 1'b1;
				node_wdata.input_mark  = is_input_q;
				node_wdata.dead_mark   = 1'b0;
				node_wdata.pair        = is_input_q ? '0 : key_q;
			end
			S_REM_CHK: begin
				node_we              = rem_ok;
				node_wdata.dead_mark = 1'b1;
			end
			S_BUMP_WR: begin
				node_we               = 1'b1;
				node_waddr            = bump_node;
				node_wdata.fanout_cnt = bump_cnt;
			end
			default: begin
			end
		endcase
	end

	// hash slot memory
	always_ff @(posedge clk) begin
		if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
		slot_rd <= slot_mem[hptr_q];
	end

	// node memory
	always_ff @(posedge clk) begin
		if (node_we) node_mem[node_waddr] <= node_wdata;
		node_rd <= node_mem[node_raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			next_free_q <= NFREE_W'(1);
			rsp_valid_q <= 1'b0;
			hptr_q      <= '0;
			key_q       <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			id_q        <= '0;
			is_input_q  <= 1'b0;
			bn0_q       <= '0;
			bn1_q       <= '0;
			bup_q       <= 1'b0;
			bsel_q      <= 1'b0;
			res_q       <= '0;
			rsp_q       <= '0;
		end else begin
			// the done state reloads the output register itself
			if (rsp_valid_q && rsp_ready && state_q != S_DONE) rsp_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + SLOT_W'(1);
					if (clr_q == SLOT_W'(HASH_SLOTS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req_valid) begin
						res_q <= idle_res;
						case (req.opcode)
							OP_INPUT: begin
								if (full) begin
									state_q <= S_DONE;
								end else begin
									id_q        <= next_free_q[NODE_W-1:0];
									is_input_q  <= 1'b1;
									next_free_q <= next_free_q + NFREE_W'(1);
									state_q     <= S_NODE_WR;
								end
							end
							OP_AND: begin
								if (trivial) begin
									state_q <= S_DONE;
								end else begin
									key_q   <= new_key;
									lo_q    <= lit_lo;
									hi_q    <= lit_hi;
									hptr_q  <= new_hash;
									state_q <= S_PROBE;
								end
							end
							OP_REMOVE: begin
								id_q    <= req.node_index;
								state_q <= S_REM_CHK;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_PROBE: state_q <= S_SLOT;
				S_SLOT: begin
					if (!slot_rd.used) begin
						if (full) begin
							res_q   <= '{result_lit: '0, created: 1'b0, status: ST_FULL};
							state_q <= S_DONE;
						end else begin
							id_q        <= next_free_q[NODE_W-1:0];
							is_input_q  <= 1'b0;
							next_free_q <= next_free_q + NFREE_W'(1);
							state_q     <= S_NODE_WR;
						end
					end else if (slot_rd.key == key_q) begin
						id_q    <= slot_rd.node;
						state_q <= S_LIVE;
					end else begin
						hptr_q  <= hptr_q + SLOT_W'(1);
						state_q <= S_PROBE;
					end
				end
				S_LIVE: begin
					if (!node_rd.dead_mark) begin
						res_q   <= '{result_lit: {id_q, 1'b0}, created: 1'b0, status: ST_OK};
						state_q <= S_DONE;
					end else begin
						hptr_q  <= hptr_q + SLOT_W'(1);
						state_q <= S_PROBE;
					end
				end
				S_NODE_WR: begin
					res_q <= '{result_lit: {id_q, 1'b0}, created: 1'b1, status: ST_OK};
					if (is_input_q) begin
						state_q <= S_DONE;
					end else begin
						bn0_q   <= lo_q[LIT_W-1:1];
						bn1_q   <= hi_q[LIT_W-1:1];
						bup_q   <= 1'b1;
						bsel_q  <= 1'b0;
						state_q <= S_BUMP_RD;
					end
				end
				S_REM_CHK: begin
					if (!rem_ok) begin
						res_q   <= '{result_lit: '0, created: 1'b0, status: ST_ILLEGAL};
						state_q <= S_DONE;
					end else begin
						res_q   <= '{result_lit: '0, created: 1'b0, status: ST_OK};
						bn0_q   <= node_rd.pair[KEY_W-1:LIT_W+1];
						bn1_q   <= node_rd.pair[LIT_W-1:1];
						bup_q   <= 1'b0;
						bsel_q  <= 1'b0;
						state_q <= S_BUMP_RD;
					end
				end
				S_BUMP_RD: state_q <= S_BUMP_WR;
				S_BUMP_WR: begin
					if (bsel_q) begin
						state_q <= S_DONE;
					end else begin
						bsel_q  <= 1'b1;
						state_q <= S_BUMP_RD;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// checks
	`AST_IMPLY(a_free_bound, 1'b1, next_free_q <= NFREE_W'(MAX_NODES), "next_free past table")
	`AST_IMPLY(a_created_ok, rsp_valid && rsp.created, rsp.status == ST_OK, "created with error")
	`AST_NEXT(a_one_item, req_valid && req_ready, !req_ready, "second item while busy")

endmodule

// File: bench/tb_aig_strash_node_table.sv
`timescale 1ns / 1ps
module tb_aig_strash_node_table;
	import aig_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 50000;
	localparam int RANDOM_ITEMS = 900;
	localparam int TAIL_ITEMS = 80;
	localparam int EXP_DEPTH = 64;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	// shadow copy of the node table
	logic [25:0] fanin_key [MAX_NODES];
	logic [12:0] ref_cnt [MAX_NODES];
	logic        is_dead [MAX_NODES];
	logic        is_input [MAX_NODES];
	int          next_node;

	// expected responses in order, written by the sender and read by the checker
	rsp_t expected_rsp [EXP_DEPTH];
	int   exp_wr = 0;
	int   exp_rd = 0;
	int   and_nodes [MAX_NODES];
	int   n_and_nodes = 0;
	bit   calm;
	int   stall_left;
	int   idle_cycles = 0;
	int   mismatches = 0;
	int   n_items, n_created, n_found, n_full, n_illegal, n_folded;

	aig_strash_node_table uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic bit is_live_and(int n);
		return n != 0 && n < next_node && n < MAX_NODES && !is_input[n] && !is_dead[n];
	endfunction

	function automatic void adjust_refs(logic [12:0] lit, bit up);
		int n;
		n = lit >> 1;
		if (up) begin
			if (ref_cnt[n] != COUNT_MAX) ref_cnt[n]++;
		end else if (ref_cnt[n] != 0) begin
			ref_cnt[n]--;
		end
	endfunction

	// expected response of one item, updating the shadow table
	function automatic rsp_t node_table_op(req_t r);
		rsp_t o;
		logic [12:0] a, b, t;
		logic [25:0] key;
		int n;
		o = '0;
		a = r.lit_a;
		b = r.lit_b;
		n = r.node_index;
		case (r.opcode)
			OP_INPUT: begin
				if (next_node >= MAX_NODES) begin
					o.status = ST_FULL;
				end else begin
					is_input[next_node] = 1'b1;
					is_dead[next_node] = 1'b0;
					fanin_key[next_node] = '0;
					o.result_lit = 13'(next_node << 1);
					o.created = 1'b1;
					next_node++;
				end
			end
			OP_AND: begin
				if (a == 0 || b == 0) begin
					n_folded++;
				end else if (a == 1) begin
					o.result_lit = b;
					n_folded++;
				end else if (b == 1 || a == b) begin
					o.result_lit = a;
					n_folded++;
				end else if (a == (b ^ 13'd1)) begin
					n_folded++;
				end else begin
					if (b < a) begin
						t = a;
						a = b;
						b = t;
					end
					key = {a, b};
					// existing live node with the same fanins
					for (int i = 1; i < next_node && i < MAX_NODES; i++) begin
						if (is_live_and(i) && fanin_key[i] == key) begin
							o.result_lit = 13'(i << 1);
							n_found++;
							return o;
						end
					end
					if (next_node >= MAX_NODES) begin
						o.status = ST_FULL;
					end else begin
						fanin_key[next_node] = key;
						is_input[next_node] = 1'b0;
						is_dead[next_node] = 1'b0;
						adjust_refs(a, 1'b1);
						adjust_refs(b, 1'b1);
						and_nodes[n_and_nodes] = next_node;
						n_and_nodes++;
						o.result_lit = 13'(next_node << 1);
						o.created = 1'b1;
						next_node++;
					end
				end
			end
			OP_REMOVE: begin
				if (!is_live_and(n) || ref_cnt[n] != 0) begin
					o.status = ST_ILLEGAL;
				end else begin
					is_dead[n] = 1'b1;
					adjust_refs(fanin_key[n][25:13], 1'b0);
					adjust_refs(fanin_key[n][12:0], 1'b0);
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	// send one item, with a random gap before it unless the run is calm
	task automatic send_item(req_t item);
		if (!calm && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		expected_rsp[exp_wr % EXP_DEPTH] = node_table_op(item);
		exp_wr++;
		n_items++;
	endtask

	task automatic send_fields(logic [1:0] op, int a, int b, int idx);
		req_t item;
		item.opcode = op;
		item.lit_a = 13'(a);
		item.lit_b = 13'(b);
		item.node_index = 12'(idx);
		send_item(item);
	endtask

	// hold the sender until every response is back
	task automatic wait_drained();
		req_valid <= 1'b0;
		while (exp_wr != exp_rd) @(posedge clk);
	endtask

	task automatic test_directed();
		int n_and;
		send_fields(OP_INPUT, 0, 0, 0);
		send_fields(OP_INPUT, 8191, 8191, 4095);
		send_fields(OP_INPUT, 0, 0, 0);
		// constant folding
		send_fields(OP_AND, 0, 5, 0);
		send_fields(OP_AND, 4, 0, 0);
		send_fields(OP_AND, 1, 5, 0);
		send_fields(OP_AND, 4, 1, 0);
		send_fields(OP_AND, 6, 6, 0);
		send_fields(OP_AND, 7, 6, 0);
		send_fields(OP_AND, 8191, 8190, 0);
		// new node, then found with swapped fanins
		send_fields(OP_AND, 4, 2, 0);
		send_fields(OP_AND, 2, 4, 0);
		n_and = next_node;
		// a fanin naming an unallocated node is used as given; then an and node as a fanin
		send_fields(OP_AND, 8191, 3, 0);
		send_fields(OP_AND, n_and * 2 - 2, 7, 0);
		// illegal removals
		send_fields(OP_REMOVE, 0, 0, 0);
		send_fields(OP_REMOVE, 0, 0, 4095);
		send_fields(OP_REMOVE, 0, 0, 1);
		send_fields(OP_REMOVE, 0, 0, n_and - 1);
		// legal removals, second removal of a dead node, rebuild
		send_fields(OP_REMOVE, 0, 0, n_and + 1);
		send_fields(OP_REMOVE, 0, 0, n_and - 1);
		send_fields(OP_REMOVE, 8191, 8191, n_and - 1);
		send_fields(OP_AND, 2, 4, 0);
		send_fields(OP_UNUSED, 8191, 8191, 4095);
		send_fields(OP_UNUSED, 0, 0, 0);
	endtask

	function automatic int pick_lit();
		if ($urandom_range(0, 9) == 0) return $urandom_range(0, 8191);
		return $urandom_range(0, next_node - 1) * 2 + $urandom_range(0, 1);
	endfunction

	task automatic test_random(int count);
		int pick, n, a, b;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				send_fields(OP_INPUT, $urandom_range(0, 8191), $urandom_range(0, 8191),
					$urandom_range(0, 4095));
			end else if (pick < 60) begin
				send_fields(OP_AND, pick_lit(), pick_lit(), $urandom_range(0, 4095));
			end else if (pick < 72 && n_and_nodes != 0) begin
				// rebuild a known pair, either order
				n = and_nodes[$urandom_range(0, n_and_nodes - 1)];
				a = fanin_key[n][25:13];
				b = fanin_key[n][12:0];
				if ($urandom_range(0, 1)) send_fields(OP_AND, b, a, 0);
				else send_fields(OP_AND, a, b, 0);
			end else if (pick < 94) begin
				// mostly recent nodes, which are the likely unreferenced ones
				if (n_and_nodes != 0 && $urandom_range(0, 9) != 0)
					n = and_nodes[$urandom_range(n_and_nodes > 8 ?
						n_and_nodes - 8 : 0, n_and_nodes - 1)];
				else
					n = $urandom_range(0, 4095);
				send_fields(OP_REMOVE, $urandom_range(0, 8191), $urandom_range(0, 8191), n);
			end else begin
				send_fields(OP_UNUSED, $urandom_range(0, 8191), $urandom_range(0, 8191),
					$urandom_range(0, 4095));
			end
		end
	endtask

	task automatic test_pause();
		wait_drained();
		send_fields(OP_AND, 2, 4, 0);
		send_fields(OP_REMOVE, 0, 0, 0);
	endtask

	// last part of the run with no idling on either side
	task automatic test_calm_tail();
		calm = 1'b1;
		test_random(TAIL_ITEMS);
		send_fields(OP_AND, 1, 8190, 0);
		send_fields(OP_UNUSED, 0, 0, 0);
	endtask

	// rsp_ready with random stall bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 13);
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	// response check against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (exp_wr == exp_rd) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: lit %0d created %0d status %0d",
						rsp.result_lit, rsp.created, rsp.status);
			end else begin
				if (rsp.result_lit !== expected_rsp[exp_rd % EXP_DEPTH].result_lit ||
						rsp.created !== expected_rsp[exp_rd % EXP_DEPTH].created ||
						rsp.status !== expected_rsp[exp_rd % EXP_DEPTH].status) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: expected lit %0d created %0d status %0d",
							expected_rsp[exp_rd % EXP_DEPTH].result_lit,
							expected_rsp[exp_rd % EXP_DEPTH].created,
							expected_rsp[exp_rd % EXP_DEPTH].status);
						$display("          got lit %0d created %0d status %0d",
							rsp.result_lit, rsp.created, rsp.status);
					end
				end
				if (expected_rsp[exp_rd % EXP_DEPTH].created) n_created++;
				if (expected_rsp[exp_rd % EXP_DEPTH].status == ST_FULL) n_full++;
				if (expected_rsp[exp_rd % EXP_DEPTH].status == ST_ILLEGAL) n_illegal++;
				exp_rd++;
			end
		end
	end

	// watchdog on cycles with no item accepted on either side
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog expired with %0d items outstanding", exp_wr - exp_rd);
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		calm = 1'b0;
		next_node = 1;
		for (int i = 0; i < MAX_NODES; i++) begin
			fanin_key[i] = '0;
			ref_cnt[i] = '0;
			is_dead[i] = 1'b0;
			is_input[i] = 1'b0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(RANDOM_ITEMS / 2);
		test_pause();
		test_random(RANDOM_ITEMS / 2);
		test_calm_tail();

		wait_drained();
		repeat (20) @(posedge clk);
		$display("%0d items: %0d nodes created, %0d found by hash, %0d folded",
			n_items, n_created, n_found, n_folded);
		$display("%0d table-full and %0d illegal-removal responses, %0d mismatches",
			n_full, n_illegal, mismatches);
		if (mismatches == 0 && exp_wr == exp_rd) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
